>>> hdl/dlhw_pkg.sv
`timescale 1ns / 1ps
// Package for the dual liveness hang watchdog: widths, reset values, request
// and register codes, the result record and the saturating helpers.
// No dependencies.
package dlhw_pkg;

  localparam int TIME_WIDTH  = 32;
  localparam int COUNT_WIDTH = 32;

  localparam int REQ_W     = 3;
  localparam int TID_W     = 7;
  localparam int THREAD_W  = 8;
  localparam int OUT_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 20;
  localparam int THR_W     = 20;
  localparam int REP_W     = 20;
  localparam int POLL_W    = 16;

  localparam logic [THR_W-1:0]  RESET_HANG_THRESHOLD  = THR_W'(3000);
  localparam logic [REP_W-1:0]  RESET_REPEAT_INTERVAL = REP_W'(2000);
  localparam logic [POLL_W-1:0] RESET_POLL_PERIOD     = POLL_W'(500);

  localparam logic [REQ_W-1:0] REQ_TICK         = 3'd0;
  localparam logic [REQ_W-1:0] REQ_YIELD        = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FRAME_END    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_RESUME_START = 3'd3;
  localparam logic [REQ_W-1:0] REQ_RESUME_END   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_HANG_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_PERIOD     = 2'd2;

  localparam logic signed [THREAD_W-1:0] THREAD_NONE = -8'sd1;

  typedef logic [TIME_WIDTH-1:0]  time_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    logic [OUT_W-1:0]           frame_idle_ms;
    logic [OUT_W-1:0]           yield_idle_ms;
    logic signed [THREAD_W-1:0] active_thread;
    logic [OUT_W-1:0]           active_elapsed_ms;
    logic [OUT_W-1:0]           frames_seen;
    logic [OUT_W-1:0]           yields_seen;
  } result_t;

  function automatic time_t sat_inc(input time_t v);
    return (v == '1) ? v : v + time_t'(1);
  endfunction

  // Clamp a timer to the 32-bit result field.
  function automatic logic [OUT_W-1:0] sat_out(input time_t v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'h0000_0000_FFFF_FFFF) ? '1 : w[OUT_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] cnt_out(input count_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[OUT_W-1:0];
  endfunction

endpackage

>>> hdl/dual_liveness_hang_watchdog.sv
`timescale 1ns / 1ps
// Top level of the dual liveness hang watchdog: event decode, timers, poll
// check, and a two-deep result buffer. Depends on dlhw_pkg.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   in_     | input     | in_valid/in_ready  | req_type, thread_num
//   out_    | output    | out_valid/out_ready| six hang report fields
//   cfg_    | input     | cfg_we             | cfg_index, cfg_wdata
//
// One beat per cycle while in_ready is high: every event updates the state in
// the cycle it is accepted, and a poll tick that finds a hang loads the report
// into the output register, or into the skid register behind it while the
// output stalls, so input keeps flowing while a report waits; in_ready drops
// only while both hold a report. Synchronous active-low reset; no clearing pass.
module dual_liveness_hang_watchdog (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [dlhw_pkg::REQ_W-1:0]            in_req_type,
  input  logic [dlhw_pkg::TID_W-1:0]            in_thread_num,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [dlhw_pkg::OUT_W-1:0]            out_frame_idle_ms,
  output logic [dlhw_pkg::OUT_W-1:0]            out_yield_idle_ms,
  output logic signed [dlhw_pkg::THREAD_W-1:0]  out_active_thread,
  output logic [dlhw_pkg::OUT_W-1:0]            out_active_elapsed_ms,
  output logic [dlhw_pkg::OUT_W-1:0]            out_frames_seen,
  output logic [dlhw_pkg::OUT_W-1:0]            out_yields_seen,
  input  logic                                  cfg_we,
  input  logic [dlhw_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dlhw_pkg::CFG_DAT_W-1:0]        cfg_wdata
);
  import dlhw_pkg::*;

  logic [THR_W-1:0]  hang_thr_r;
  logic [REP_W-1:0]  repeat_int_r;
  logic [POLL_W-1:0] poll_period_r;

  count_t yield_cnt_r, yield_cnt_nxt;
  count_t frame_cnt_r, frame_cnt_nxt;
  count_t yield_seen_r, yield_seen_nxt;
  count_t frame_seen_r, frame_seen_nxt;
  time_t  idle_yield_r, idle_yield_nxt;
  time_t  idle_frame_r, idle_frame_nxt;
  time_t  since_rpt_r, since_rpt_nxt;
  time_t  run_time_r, run_time_nxt;
  logic [POLL_W-1:0] poll_cnt_r, poll_cnt_nxt;
  logic signed [THREAD_W-1:0] run_thread_r, run_thread_nxt;

  logic    out_valid_r, skid_valid_r;
  result_t out_r, skid_r;

  logic    accept;
  logic    rpt;
  result_t rpt_data;
  time_t   iy_tick, if_tick, sr_tick;
  logic    thread_active;

  assign in_ready      = !skid_valid_r;
  assign accept        = in_valid && in_ready;
  assign thread_active = !run_thread_r[THREAD_W-1];

  always_comb begin
    yield_cnt_nxt  = yield_cnt_r;
    frame_cnt_nxt  = frame_cnt_r;
    yield_seen_nxt = yield_seen_r;
    frame_seen_nxt = frame_seen_r;
    idle_yield_nxt = idle_yield_r;
    idle_frame_nxt = idle_frame_r;
    since_rpt_nxt  = since_rpt_r;
    run_time_nxt   = run_time_r;
    poll_cnt_nxt   = poll_cnt_r;
    run_thread_nxt = run_thread_r;
    rpt            = 1'b0;
    iy_tick        = sat_inc(idle_yield_r);
    if_tick        = sat_inc(idle_frame_r);
    sr_tick        = sat_inc(since_rpt_r);

    rpt_data.frame_idle_ms     = '0;
    rpt_data.yield_idle_ms     = '0;
    rpt_data.active_thread     = run_thread_r;
    rpt_data.active_elapsed_ms = '0;
    rpt_data.frames_seen       = cnt_out(frame_cnt_r);
    rpt_data.yields_seen       = cnt_out(yield_cnt_r);

    if (accept) begin
      unique case (in_req_type)
        REQ_TICK: begin
          idle_yield_nxt = iy_tick;
          idle_frame_nxt = if_tick;
          since_rpt_nxt  = sr_tick;
          if (thread_active) begin
            run_time_nxt = sat_inc(run_time_r);
          end
          if (poll_cnt_r <= POLL_W'(1)) begin
            poll_cnt_nxt = (poll_period_r == '0) ? POLL_W'(1) : poll_period_r;
            // a counter that moved since the last poll restarts its idle time
            if (yield_cnt_r != yield_seen_r) begin
              yield_seen_nxt = yield_cnt_r;
              idle_yield_nxt = '0;
            end
            if (frame_cnt_r != frame_seen_r) begin
              frame_seen_nxt = frame_cnt_r;
              idle_frame_nxt = '0;
            end
            rpt = (frame_cnt_r != '0)
               && (64'(idle_frame_nxt) > 64'(hang_thr_r))
               && (64'(idle_yield_nxt) > 64'(hang_thr_r))
               && (64'(sr_tick) >= 64'(repeat_int_r));
            if (rpt) begin
              since_rpt_nxt = '0;
            end
          end else begin
            poll_cnt_nxt = poll_cnt_r - POLL_W'(1);
          end
          rpt_data.frame_idle_ms     = sat_out(idle_frame_nxt);
          rpt_data.yield_idle_ms     = sat_out(idle_yield_nxt);
          rpt_data.active_elapsed_ms = thread_active ? sat_out(run_time_nxt) : '0;
        end
        REQ_YIELD: begin
          yield_cnt_nxt = yield_cnt_r + count_t'(1);
        end
        REQ_FRAME_END: begin
          frame_cnt_nxt = frame_cnt_r + count_t'(1);
        end
        REQ_RESUME_START: begin
          run_thread_nxt = $signed({1'b0, in_thread_num});
          run_time_nxt   = '0;
        end
        REQ_RESUME_END: begin
          run_thread_nxt = THREAD_NONE;
          run_time_nxt   = '0;
        end
        default: begin
          // drop unknown requests
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hang_thr_r    <= RESET_HANG_THRESHOLD;
      repeat_int_r  <= RESET_REPEAT_INTERVAL;
      poll_period_r <= RESET_POLL_PERIOD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HANG_THRESHOLD:  hang_thr_r    <= cfg_wdata[THR_W-1:0];
        CFG_REPEAT_INTERVAL: repeat_int_r  <= cfg_wdata[REP_W-1:0];
        CFG_POLL_PERIOD:     poll_period_r <= cfg_wdata[POLL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yield_cnt_r  <= '0;
      frame_cnt_r  <= '0;
      yield_seen_r <= '0;
      frame_seen_r <= '0;
      idle_yield_r <= '0;
      idle_frame_r <= '0;
      since_rpt_r  <= '1;
      run_time_r   <= '0;
      poll_cnt_r   <= RESET_POLL_PERIOD;
      run_thread_r <= THREAD_NONE;
    end else begin
      yield_cnt_r  <= yield_cnt_nxt;
      frame_cnt_r  <= frame_cnt_nxt;
      yield_seen_r <= yield_seen_nxt;
      frame_seen_r <= frame_seen_nxt;
      idle_yield_r <= idle_yield_nxt;
      idle_frame_r <= idle_frame_nxt;
      since_rpt_r  <= since_rpt_nxt;
      run_time_r   <= run_time_nxt;
      poll_cnt_r   <= poll_cnt_nxt;
      run_thread_r <= run_thread_nxt;
    end
  end

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= rpt;
      end
    end else if (rpt) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_r <= skid_valid_r ? skid_r : rpt_data;
    end else if (rpt) begin
      skid_r <= rpt_data;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_frame_idle_ms     = out_r.frame_idle_ms;
  assign out_yield_idle_ms     = out_r.yield_idle_ms;
  assign out_active_thread     = out_r.active_thread;
  assign out_active_elapsed_ms = out_r.active_elapsed_ms;
  assign out_frames_seen       = out_r.frames_seen;
  assign out_yields_seen       = out_r.yields_seen;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a report while the output register is empty");

  a_report_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
    rpt |=> (since_rpt_r == '0) && out_valid_r)
    else $error("hang report did not clear the report timer or raise out_valid");

  a_poll_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    poll_cnt_r != '0)
    else $error("poll countdown reached zero");

  a_idle_thread_no_time: assert property (@(posedge clk) disable iff (!rst_n)
    !thread_active |-> (run_time_r == '0))
    else $error("run time nonzero with no active thread");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for dual_liveness_hang_watchdog: tick and liveness event
// beats in, hang reports predicted by a scoreboard class and checked field by field.
// Depends on dlhw_pkg and the watchdog RTL.
module testbench;
  import dlhw_pkg::*;

  localparam int unsigned STALL_LIMIT      = 2000;
  localparam int unsigned HOLD_CYCLES      = 300;
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned MAX_PAUSE        = 14;
  localparam int unsigned SHOWN_MISMATCHES = 10;
  localparam int unsigned RANDOM_PHASES    = 12;
  localparam int unsigned PHASE_ITEMS      = 100;

  class hang_report_tracker;
    logic [THR_W-1:0]           hang_limit;
    logic [REP_W-1:0]           report_spacing;
    logic [POLL_W-1:0]          poll_ticks;
    count_t                     yields, frames, yields_polled, frames_polled;
    time_t                      idle_yield, idle_frame, since_report, run_time;
    logic [POLL_W-1:0]          countdown;
    logic signed [THREAD_W-1:0] thread;
    result_t                    reports[$];
    int unsigned                mismatches;

    function new();
      hang_limit     = RESET_HANG_THRESHOLD;
      report_spacing = RESET_REPEAT_INTERVAL;
      poll_ticks     = RESET_POLL_PERIOD;
      yields         = '0;
      frames         = '0;
      yields_polled  = '0;
      frames_polled  = '0;
      idle_yield     = '0;
      idle_frame     = '0;
      since_report   = '1;
      run_time       = '0;
      countdown      = RESET_POLL_PERIOD;
      thread         = THREAD_NONE;
      mismatches     = 0;
    endfunction

    function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      case (idx)
        CFG_HANG_THRESHOLD:  hang_limit = THR_W'(val);
        CFG_REPEAT_INTERVAL: report_spacing = REP_W'(val);
        CFG_POLL_PERIOD:     poll_ticks = val[POLL_W-1:0];
        default: ;
      endcase
    endfunction

    function time_t grow(time_t v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function void poll();
      result_t r;
      if (yields != yields_polled) begin
        yields_polled = yields;
        idle_yield = '0;
      end
      if (frames != frames_polled) begin
        frames_polled = frames;
        idle_frame = '0;
      end
      // no report before the first frame has ended
      if (frames == '0) return;
      if (idle_frame <= time_t'(hang_limit) || idle_yield <= time_t'(hang_limit)) return;
      if (since_report < time_t'(report_spacing)) return;
      since_report = '0;
      r.frame_idle_ms     = OUT_W'(idle_frame);
      r.yield_idle_ms     = OUT_W'(idle_yield);
      r.active_thread     = thread;
      r.active_elapsed_ms = (thread != THREAD_NONE) ? OUT_W'(run_time) : '0;
      r.frames_seen       = OUT_W'(frames);
      r.yields_seen       = OUT_W'(yields);
      reports.push_back(r);
    endfunction

    function void note_input(logic [REQ_W-1:0] req, logic [TID_W-1:0] tid);
      case (req)
        REQ_TICK: begin
          // timers advance first, the poll sees the new values
          idle_yield   = grow(idle_yield);
          idle_frame   = grow(idle_frame);
          since_report = grow(since_report);
          if (thread != THREAD_NONE) run_time = grow(run_time);
          if (countdown <= 1) begin
            countdown = (poll_ticks == '0) ? POLL_W'(1) : poll_ticks;
            poll();
          end else begin
            countdown = countdown - 1'b1;
          end
        end
        REQ_YIELD:     yields = yields + 1'b1;
        REQ_FRAME_END: frames = frames + 1'b1;
        REQ_RESUME_START: begin
          thread   = {1'b0, tid};
          run_time = '0;
        end
        REQ_RESUME_END: begin
          thread   = THREAD_NONE;
          run_time = '0;
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string field, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("mismatch on %s: expected %0h, got %0h", field, want, got);
      end
    endfunction

    function void check_report(result_t got);
      result_t want;
      if (reports.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("report with none expected: frames_seen %0d yields_seen %0d",
                   got.frames_seen, got.yields_seen);
        return;
      end
      want = reports.pop_front();
      compare_field("frame_idle_ms", want.frame_idle_ms, got.frame_idle_ms);
      compare_field("yield_idle_ms", want.yield_idle_ms, got.yield_idle_ms);
      compare_field("active_thread", want.active_thread, got.active_thread);
      compare_field("active_elapsed_ms", want.active_elapsed_ms, got.active_elapsed_ms);
      compare_field("frames_seen", want.frames_seen, got.frames_seen);
      compare_field("yields_seen", want.yields_seen, got.yields_seen);
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [REQ_W-1:0]             in_req_type;
  logic [TID_W-1:0]             in_thread_num;
  logic                         out_valid;
  logic                         out_ready;
  logic [OUT_W-1:0]             out_frame_idle_ms;
  logic [OUT_W-1:0]             out_yield_idle_ms;
  logic signed [THREAD_W-1:0]   out_active_thread;
  logic [OUT_W-1:0]             out_active_elapsed_ms;
  logic [OUT_W-1:0]             out_frames_seen;
  logic [OUT_W-1:0]             out_yields_seen;
  logic                         cfg_we;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_DAT_W-1:0]         cfg_wdata;

  hang_report_tracker tracker;
  bit                 hold_request = 1'b0;
  int unsigned        send_calm = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  dual_liveness_hang_watchdog dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_req_type           (in_req_type),
    .in_thread_num         (in_thread_num),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_frame_idle_ms     (out_frame_idle_ms),
    .out_yield_idle_ms     (out_yield_idle_ms),
    .out_active_thread     (out_active_thread),
    .out_active_elapsed_ms (out_active_elapsed_ms),
    .out_frames_seen       (out_frames_seen),
    .out_yields_seen       (out_yields_seen),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  // Mostly random pauses, now and then a stretch with none.
  function automatic int unsigned draw_pause(inout int unsigned calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, MAX_PAUSE);
  endfunction

  task automatic send_item(input logic [REQ_W-1:0] req, input logic [TID_W-1:0] tid);
    int unsigned pause;
    pause = draw_pause(send_calm);
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_thread_num <= tid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_input(req, tid);
  endtask

  // Drop valid and wait out every expected report plus the output latency.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DAT_W'(val);
    @(posedge clk);
    tracker.configure(idx, CFG_DAT_W'(val));
  endtask

  task automatic apply_settings(input int unsigned thr, input int unsigned spacing,
                                input int unsigned poll);
    write_register(CFG_HANG_THRESHOLD, thr);
    write_register(CFG_REPEAT_INTERVAL, spacing);
    write_register(CFG_POLL_PERIOD, poll);
    cfg_we <= 1'b0;
  endtask

  // Active bursts (frame, yield, thread events) followed by quiet tick runs that, for
  // small thresholds, can be long enough to cross them, with some noise beats mixed in.
  task automatic run_random_phase(input int unsigned quota);
    int unsigned      sent, run, cap, k;
    logic [REQ_W-1:0] req;
    sent = 0;
    if (tracker.hang_limit < 30 && tracker.poll_ticks < 30)
      cap = 2 * (int'(tracker.hang_limit) + int'(tracker.poll_ticks)) + 6;
    else
      cap = 60;
    while (sent < quota) begin
      if ($urandom_range(0, 9) == 0) begin
        req = REQ_W'($urandom_range(0, (1 << REQ_W) - 1));
        send_item(req, TID_W'($urandom));
        if (req <= REQ_RESUME_END) sent++;
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          send_item(REQ_FRAME_END, TID_W'($urandom));
          sent++;
        end
        if ($urandom_range(0, 2) != 0) begin
          send_item(REQ_YIELD, TID_W'($urandom));
          sent++;
        end
        case ($urandom_range(0, 3))
          0: begin
            send_item(REQ_RESUME_START, TID_W'($urandom));
            sent++;
          end
          1: begin
            send_item(REQ_RESUME_END, TID_W'($urandom));
            sent++;
          end
          default: ;
        endcase
        run = $urandom_range(0, cap);
        for (k = 0; k < run && sent < quota; k++) begin
          send_item(REQ_TICK, TID_W'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin : receive_side
    int unsigned pause, calm;
    result_t     got;
    calm = 0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        pause = HOLD_CYCLES;
      end else begin
        pause = draw_pause(calm);
      end
      if (pause > 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.frame_idle_ms     = out_frame_idle_ms;
      got.yield_idle_ms     = out_yield_idle_ms;
      got.active_thread     = out_active_thread;
      got.active_elapsed_ms = out_active_elapsed_ms;
      got.frames_seen       = out_frames_seen;
      got.yields_seen       = out_yields_seen;
      tracker.check_report(got);
    end
  end

  initial begin : stall_watch
    int unsigned stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int          r;
    int unsigned p, thr, spacing, poll;
    tracker = new();
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_req_type   <= REQ_TICK;
    in_thread_num <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_HANG_THRESHOLD;
    cfg_wdata     <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // poll on every tick, report on every hang
    apply_settings(1, 0, 1);
    // run out the reset countdown so the short period takes hold
    repeat (RESET_POLL_PERIOD) send_item(REQ_TICK, '0);
    send_item(REQ_TICK, '0);
    for (r = int'(REQ_RESUME_END) + 1; r < (1 << REQ_W); r++)
      send_item(REQ_W'(r), '1);
    send_item(REQ_RESUME_END, '0);
    send_item(REQ_RESUME_START, '1);
    send_item(REQ_RESUME_START, '0);
    send_item(REQ_YIELD, '0);
    send_item(REQ_FRAME_END, '0);
    repeat (4) send_item(REQ_TICK, '0);
    send_item(REQ_RESUME_END, '0);
    repeat (2) send_item(REQ_TICK, '0);

    // hold the report side off while every tick reports, so the input backs up
    hold_request = 1'b1;
    repeat (20) send_item(REQ_TICK, TID_W'($urandom));
    drain();

    apply_settings(1, 0, 0);
    run_random_phase(120);

    for (p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      case ($urandom_range(0, 7))
        0:       thr = 1000000;
        1:       thr = 1;
        default: thr = $urandom_range(1, 25);
      endcase
      case ($urandom_range(0, 7))
        0:       spacing = 0;
        1:       spacing = 1000000;
        default: spacing = $urandom_range(0, 60);
      endcase
      poll = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8);
      apply_settings(thr, spacing, poll);
      run_random_phase(PHASE_ITEMS);
    end

    // largest settings last: the long countdown they leave behind never ends
    drain();
    apply_settings(1000000, 1000000, 65535);
    run_random_phase(40);
    drain();

    if (tracker.mismatches == 0 && tracker.reports.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
